>>> rtl/pip_pkg.sv
package pip_pkg;

    // Default coordinate width
    localparam int COORD_BITS_DEF = 16;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_FINISH
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;     // capture an edge word and classify it
        logic mul;      // form the product and seed the divider
        logic step;     // one quotient bit
        logic finish;   // fold the hit into parity, emit on last edge
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic needs_div;  // edge in span with exactly one endpoint below
        logic last;       // captured word is the polygon's last edge
    } t_dp_sts;

endpackage

>>> rtl/pip_dp.sv
module pip_dp
    import pip_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic [COORD_BITS-1:0] i_point_x,
    input  logic [COORD_BITS-1:0] i_point_y,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    input  logic                  i_final_edge,
    output logic                  o_inside_res
);

    localparam int N = COORD_BITS;

    // Captured edge operands
    logic [N-1:0] r_py, r_ly, r_dx, r_d, r_dy_mag;
    logic         r_neg, r_span, r_both, r_one, r_last;
    // Divider
    logic [N-1:0] r_rem, r_dvd;
    // Parity and result
    logic         r_parity, r_inside;

    logic         a_below, b_below, a_low, in_span;
    logic [N-1:0] lx, ly, hx, hy;
    logic [N:0]   dy;
    logic [2*N-1:0] prod;
    logic [N:0]   div_sh;
    logic         div_ge;
    logic [N-1:0] div_sub;
    logic signed [N+1:0] sq, cross_y;
    logic         cross_below, hit, parity_nx;

    // Edge classification on the incoming word
    always_comb begin
        a_below = i_start_y < i_point_y;
        b_below = i_end_y < i_point_y;
        in_span = ((i_point_x >= i_start_x) && (i_point_x < i_end_x)) ||
                  ((i_point_x < i_start_x) && (i_point_x >= i_end_x));
        a_low   = i_start_x < i_end_x;
        lx = a_low ? i_start_x : i_end_x;
        ly = a_low ? i_start_y : i_end_y;
        hx = a_low ? i_end_x   : i_start_x;
        hy = a_low ? i_end_y   : i_start_y;
        dy = {1'b0, hy} - {1'b0, ly};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_py     <= i_point_y;
            r_ly     <= ly;
            r_dx     <= i_point_x - lx;
            r_d      <= hx - lx;
            r_neg    <= dy[N];
            r_dy_mag <= dy[N] ? N'(-dy) : dy[N-1:0];
            r_span   <= in_span;
            r_both   <= a_below && b_below;
            r_one    <= a_below ^ b_below;
            r_last   <= i_final_edge;
        end
    end

    // Product magnitude; its high half is below the divisor
    assign prod = r_dx * r_dy_mag;

    // Restoring divider step; the difference is kept only when it fits
    always_comb begin
        div_sh  = {r_rem, r_dvd[N-1]};
        div_ge  = div_sh >= {1'b0, r_d};
        div_sub = N'(div_sh - {1'b0, r_d});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_rem <= prod[2*N-1:N];
            r_dvd <= prod[N-1:0];
        end else if (i_cmd.step) begin
            r_rem <= div_ge ? div_sub : div_sh[N-1:0];
            r_dvd <= {r_dvd[N-2:0], div_ge};
        end
    end

    // Crossing y against the point, quotient truncated toward zero
    always_comb begin
        sq = r_neg ? -$signed({2'b00, r_dvd}) : $signed({2'b00, r_dvd});
        cross_y     = $signed({2'b00, r_ly}) + sq;
        cross_below = cross_y < $signed({2'b00, r_py});
        hit         = r_span && (r_both || (r_one && cross_below));
        parity_nx   = r_parity ^ hit;
    end

    // Parity and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity <= 1'b0;
        end else if (i_cmd.finish) begin
            r_parity <= r_last ? 1'b0 : parity_nx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && r_last) begin
            r_inside <= parity_nx;
        end
    end

    assign o_sts.needs_div = r_span && r_one;
    assign o_sts.last      = r_last;
    assign o_inside_res    = r_inside;

endmodule

>>> rtl/pip_ctrl.sv
module pip_ctrl
    import pip_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    localparam int CW = $clog2(COORD_BITS);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic          out_busy;

    // State, counter and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        out_busy    = r_out_valid && !i_out_ready;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_cnt = '0;
                if (i_sts.needs_div) begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CW'(COORD_BITS - 1)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // wait for a free output register on the last edge
                if (!(i_sts.last && out_busy)) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                    if (i_sts.last) begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

    // An accepted word always moves to classification
    a_load_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_CHECK))
        else $error("accepted word did not enter check");

    // Divider count stays within the coordinate width
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= CW'(COORD_BITS - 1)))
        else $error("divider count out of range");

    // A result appears only from finishing a last edge
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_cmd.finish && i_sts.last))
        else $error("result without last edge");

    // Finish never overwrites a pending result
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.finish && i_sts.last) |-> !out_busy)
        else $error("result overwritten");

endmodule

>>> rtl/point_in_polygon_parity.sv
// Crossing-number point-in-polygon test, one polygon edge per input word.
// Input channel (i_in_valid / o_in_ready) carries the query point, the
// edge endpoints and i_final_edge. Each edge in the point's half-open x
// span that passes below the point toggles a parity bit. On the last
// edge one output word (o_out_valid / i_out_ready) carries o_inside_res
// and the parity clears for the next polygon.
// Per edge: an edge that needs no crossing-y computation goes from accept
// through check and finish back to idle; an edge with exactly one endpoint
// below the point also passes the restoring divider, which resolves one
// quotient bit a cycle. No new edge is accepted until the current one finishes.
// The result is valid the cycle after the last edge finishes.
// The output register decouples the sides: new edges are accepted while
// a result waits. If the receiver stalls and another last edge finishes,
// the block holds that edge until the pending result is taken.
// Reset (i_rst_n low, synchronous) clears parity and drops o_out_valid.
module point_in_polygon_parity
    import pip_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [COORD_BITS-1:0] i_point_x,
    input  logic [COORD_BITS-1:0] i_point_y,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    input  logic                  i_final_edge,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_inside_res
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer
    pip_ctrl #(
        .COORD_BITS(COORD_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Edge test, multiplier, divider and parity
    pip_dp #(
        .COORD_BITS(COORD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_final_edge (i_final_edge),
        .o_inside_res (o_inside_res)
    );

endmodule

>>> dv/point_in_polygon_parity_tb.sv
`timescale 1ns / 1ps

module point_in_polygon_parity_tb;
    import pip_pkg::*;

    localparam int CW          = COORD_BITS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 2 * (CW + 3) + 10;

    typedef logic [CW-1:0] t_coord;

    logic   i_clk        = 1'b0;
    logic   i_rst_n      = 1'b0;
    logic   i_in_valid   = 1'b0;
    logic   o_in_ready;
    t_coord i_point_x    = '0;
    t_coord i_point_y    = '0;
    t_coord i_start_x    = '0;
    t_coord i_start_y    = '0;
    t_coord i_end_x      = '0;
    t_coord i_end_y      = '0;
    logic   i_final_edge = 1'b0;
    logic   o_out_valid;
    logic   i_out_ready  = 1'b0;
    logic   o_inside_res;

    // predictor state and expected inside flags, oldest first
    logic   polygon_parity = 1'b0;
    logic   inside_q[$];
    int     err_cnt        = 0;
    int     cycle_cnt      = 0;
    int     hold_cycles    = 0;
    bit     no_idle        = 1'b0;

    point_in_polygon_parity #(
        .COORD_BITS(CW)
    ) i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("point_in_polygon_parity_tb failed");
            $finish;
        end
    end

    // receiver: forced hold-off first, then always ready in full-rate mode, else random stalls
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (no_idle) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= 33);
        end
    end

    // compare each output word against the oldest expected flag
    always @(posedge i_clk) begin
        logic exp_inside;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (inside_q.size() == 0) begin
                $display("%0t: unexpected output word, inside_res=%0b", $time, o_inside_res);
                err_cnt++;
            end else begin
                exp_inside = inside_q.pop_front();
                if (o_inside_res !== exp_inside) begin
                    $display("%0t: inside_res mismatch, expected %0b actual %0b",
                             $time, exp_inside, o_inside_res);
                    err_cnt++;
                end
            end
        end
    end

    // half-open x span, then below test with truncating crossing y
    function automatic logic edge_crosses(t_coord px, t_coord py, t_coord ax, t_coord ay,
                                          t_coord bx, t_coord by);
        longint lx, ly, hx, hy, cross_y;
        if (!((px >= ax && px < bx) || (px < ax && px >= bx)))
            return 1'b0;
        if (ay < py && by < py)
            return 1'b1;
        if (!(ay < py || by < py))
            return 1'b0;
        if (ax < bx) begin
            lx = ax; ly = ay; hx = bx; hy = by;
        end else begin
            lx = bx; ly = by; hx = ax; hy = ay;
        end
        cross_y = ly + ((longint'(px) - lx) * (hy - ly)) / (hx - lx);
        return cross_y < longint'(py);
    endfunction

    // mostly near the center so edges straddle the point, some extremes
    function automatic t_coord pick_coord(t_coord center);
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return t_coord'($urandom);
            4:       return center;
            default: return center + t_coord'($urandom_range(512)) - t_coord'(256);
        endcase
    endfunction

    // drive one edge word, hold it until accepted, then update the prediction
    task automatic send_edge(input t_coord px, input t_coord py, input t_coord ax,
                             input t_coord ay, input t_coord bx, input t_coord by,
                             input logic last);
        int gap;
        gap = (!no_idle && $urandom_range(99) < 33) ? $urandom_range(20, 1) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        i_point_x    <= px;
        i_point_y    <= py;
        i_start_x    <= ax;
        i_start_y    <= ay;
        i_end_x      <= bx;
        i_end_y      <= by;
        i_final_edge <= last;
        i_in_valid   <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        if (edge_crosses(px, py, ax, ay, bx, by))
            polygon_parity = ~polygon_parity;
        if (last) begin
            inside_q.push_back(polygon_parity);
            polygon_parity = 1'b0;
        end
    endtask

    // closed polygons around one query point
    task automatic test_random_polygons(input int n_items);
        t_coord vx[8], vy[8];
        t_coord px, py;
        int     nv, sent;
        sent = 0;
        while (sent < n_items) begin
            nv = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : $urandom_range(8, 3);
            px = ($urandom_range(7) == 0) ? pick_coord('1) : t_coord'($urandom);
            py = ($urandom_range(7) == 0) ? pick_coord('0) : t_coord'($urandom);
            for (int i = 0; i < nv; i++) begin
                vx[i] = pick_coord(px);
                vy[i] = pick_coord(py);
            end
            for (int i = 0; i < nv; i++) begin
                send_edge(px, py, vx[i], vy[i], vx[(i + 1) % nv], vy[(i + 1) % nv],
                          i == nv - 1);
                sent++;
            end
        end
    endtask

    // unrelated edges, point changing word to word, random last marks
    task automatic test_noise(input int n_items);
        t_coord px, py;
        for (int i = 0; i < n_items; i++) begin
            px = t_coord'($urandom);
            py = t_coord'($urandom);
            send_edge(px, py, pick_coord(px), pick_coord(py), pick_coord(px), pick_coord(py),
                      $urandom_range(3) == 0);
        end
        send_edge('0, '0, '0, '0, '1, '1, 1'b1);
    endtask

    // extremes, vertical edge, slope signs, truncation, parity clear
    task automatic test_directed();
        // vertical edge below the point: empty span
        send_edge(16'd100, 16'd100, 16'd100, 16'd0, 16'd100, 16'd50, 1'b1);
        // both endpoints below, in span
        send_edge(16'd100, 16'd100, 16'd50, 16'd10, 16'd150, 16'd20, 1'b1);
        // point at the top corner, span is half-open
        send_edge('1, '1, '0, '0, '1, '0, 1'b0);
        send_edge('1, '1, '1, '0, '0, '0, 1'b1);
        // point at the origin: nothing lies below
        send_edge('0, '0, '0, '0, '1, '1, 1'b1);
        // one endpoint below, crossing y just under and exactly at the point
        send_edge(16'd50, 16'd101, 16'd0, 16'd0, 16'd100, 16'd200, 1'b1);
        send_edge(16'd50, 16'd100, 16'd0, 16'd0, 16'd100, 16'd200, 1'b1);
        // negative slope: quotient truncates toward zero
        send_edge(16'd1, 16'd134, 16'd0, 16'd200, 16'd3, 16'd0, 1'b1);
        send_edge(16'd1, 16'd135, 16'd0, 16'd200, 16'd3, 16'd0, 1'b1);
        // endpoints given in reverse x order
        send_edge(16'd1, 16'd135, 16'd3, 16'd0, 16'd0, 16'd200, 1'b1);
        // full-range divide
        send_edge(16'hFFFE, 16'hFFFE, '0, '0, '1, '1, 1'b1);
        send_edge(16'hFFFE, 16'hFFFF, '0, '0, '1, '1, 1'b1);
        send_edge(16'h0001, 16'hFFFF, '1, '0, '0, '1, 1'b1);
        // triangle, point inside
        send_edge(16'd50, 16'd40, 16'd10, 16'd10, 16'd100, 16'd10, 1'b0);
        send_edge(16'd50, 16'd40, 16'd100, 16'd10, 16'd50, 16'd100, 1'b0);
        send_edge(16'd50, 16'd40, 16'd50, 16'd100, 16'd10, 16'd10, 1'b1);
        // same triangle, point outside
        send_edge(16'd200, 16'd40, 16'd10, 16'd10, 16'd100, 16'd10, 1'b0);
        send_edge(16'd200, 16'd40, 16'd100, 16'd10, 16'd50, 16'd100, 1'b0);
        send_edge(16'd200, 16'd40, 16'd50, 16'd100, 16'd10, 16'd10, 1'b1);
        // two hits cancel, then a fresh polygon starts from zero parity
        send_edge(16'd100, 16'd100, 16'd50, 16'd10, 16'd150, 16'd20, 1'b0);
        send_edge(16'd100, 16'd100, 16'd150, 16'd30, 16'd50, 16'd40, 1'b0);
        send_edge(16'd100, 16'd100, 16'd0, '1, 16'd200, '1, 1'b1);
        send_edge(16'd100, 16'd100, 16'd50, 16'd10, 16'd150, 16'd20, 1'b1);
    endtask

    // receiver holds off while last edges keep coming: block must stall input
    task automatic test_backpressure();
        @(posedge i_clk);
        hold_cycles = 300;
        for (int i = 0; i < 12; i++)
            send_edge(t_coord'($urandom), t_coord'($urandom), t_coord'($urandom),
                      t_coord'($urandom), t_coord'($urandom), t_coord'($urandom),
                      i % 2 == 1);
    endtask

    // back to back words with the receiver always ready
    task automatic test_full_rate();
        no_idle = 1'b1;
        test_random_polygons(90);
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_polygons(300);
        test_backpressure();
        test_full_rate();
        test_noise(100);
        test_random_polygons(130);

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // drain outstanding words, then allow trailing activity to settle
        while (inside_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("point_in_polygon_parity_tb passed");
        end else begin
            $display("point_in_polygon_parity_tb failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/pip_pkg.sv
rtl/pip_dp.sv
rtl/pip_ctrl.sv
rtl/point_in_polygon_parity.sv
dv/point_in_polygon_parity_tb.sv
